// File: src/wrts_pkg.sv
// Shared types and constants for the weekly relay time switch.
`default_nettype none

package wrts_pkg;

    localparam int unsigned DAYS_PER_WEEK = 7;
    localparam logic [5:0] LAST_MINUTE = 6'd59;
    localparam logic [6:0] MINUTES_PER_HOUR = 7'd60;
    localparam logic [4:0] LAST_HOUR = 5'd23;
    localparam logic [5:0] MAX_RUN = 6'd60;
    localparam logic [2:0] SUNDAY = 3'd7;
    localparam logic [2:0] MONDAY = 3'd1;

    typedef logic [2:0] day_t;
    typedef logic [4:0] hour_t;
    typedef logic [5:0] minute_t;
    typedef logic [6:0] mask_t;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_SWITCH = 2'd1,
        KIND_MODE   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CFG_START_HOUR   = 2'd0,
        CFG_START_MINUTE = 2'd1,
        CFG_DAY_MASK     = 2'd2,
        CFG_RUN_MINUTES  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic    found;
        day_t    start_day;
        day_t    stop_day;
        hour_t   stop_hour;
        minute_t stop_minute;
    } sched_t;

endpackage

`default_nettype wire

// File: src/wrts_sched.sv
// Next start search over the week and stop time derivation.
`default_nettype none

module wrts_sched (
    input  wire wrts_pkg::day_t    weekday,
    input  wire wrts_pkg::hour_t   hour,
    input  wire wrts_pkg::minute_t minute,
    input  wire wrts_pkg::hour_t   start_hour,
    input  wire wrts_pkg::minute_t start_minute,
    input  wire wrts_pkg::minute_t run_minutes,
    input  wire wrts_pkg::mask_t   day_mask,
    output wrts_pkg::sched_t       sched
);
    import wrts_pkg::*;

    logic [7:0] cand;
    day_t       cand_day [8];
    logic [3:0] day_sum  [8];
    day_t       pick_day;
    logic       today_open;
    logic [6:0] stop_sum;
    minute_t    stop_min;

    assign today_open = (hour < start_hour) || (hour == start_hour && minute <= start_minute);

    // rotate through today and the next seven days
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            day_sum[i] = {1'b0, weekday} + 4'(i);
            if (day_sum[i] > 4'(DAYS_PER_WEEK))
            begin
                day_sum[i] = day_sum[i] - 4'(DAYS_PER_WEEK);
            end
            cand_day[i] = day_sum[i][2:0];
            cand[i] = day_mask[3'(cand_day[i] - MONDAY)];
        end
        cand[0] = cand[0] && today_open;
    end

    // take the earliest candidate
    always_comb
    begin
        pick_day = SUNDAY;
        for (int i = 7; i >= 0; i--)
        begin
            if (cand[i])
            begin
                pick_day = cand_day[i];
            end
        end
    end

    assign stop_sum = {1'b0, start_minute} + {1'b0, run_minutes};
    assign stop_min = 6'(stop_sum - MINUTES_PER_HOUR);

    always_comb
    begin
        sched.found = |cand;
        sched.start_day = pick_day;
        if (stop_sum <= {1'b0, LAST_MINUTE})
        begin
            sched.stop_minute = stop_sum[5:0];
            sched.stop_hour = start_hour;
            sched.stop_day = pick_day;
        end
        else if (start_hour >= LAST_HOUR)
        begin
            sched.stop_minute = stop_min;
            sched.stop_hour = '0;
            sched.stop_day = (pick_day >= SUNDAY) ? MONDAY : 3'(pick_day + 3'd1);
        end
        else
        begin
            sched.stop_minute = stop_min;
            sched.stop_hour = 5'(start_hour + 5'd1);
            sched.stop_day = pick_day;
        end
    end

endmodule

`default_nettype wire

// File: src/weekly_relay_time_switch_top.sv
// Top level of the weekly relay time switch: registers, state update and handshakes.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | kind weekday hour minute switch_value mode_value
//   out     | output    | out_valid / out_stall| relay_drive auto_mode schedule_empty next_* fields
//   cfg     | input     | cfg_we               | cfg_index cfg_wdata
//
// An item passes from input to result through the input register, then the result register.
// Unless stalled, one item is accepted per cycle; the state update is one pass of logic between them.
// Reset clears valids and sets schedule state and config registers; payload registers are not reset.
// A held result stalls the input register only, which still accepts while empty.
`default_nettype none

module weekly_relay_time_switch_top (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire [1:0]              kind,
    input  wire wrts_pkg::day_t    weekday,
    input  wire wrts_pkg::hour_t   hour,
    input  wire wrts_pkg::minute_t minute,
    input  wire                    switch_value,
    input  wire                    mode_value,
    output logic                   out_valid,
    input  wire                    out_stall,
    output logic                   relay_drive,
    output logic                   auto_mode,
    output logic                   schedule_empty,
    output wrts_pkg::day_t         next_start_day,
    output wrts_pkg::day_t         next_stop_day,
    output wrts_pkg::hour_t        next_stop_hour,
    output wrts_pkg::minute_t      next_stop_minute,
    input  wire                    cfg_we,
    input  wire [1:0]              cfg_index,
    input  wire [6:0]              cfg_wdata
);
    import wrts_pkg::*;

    hour_t   start_hour_reg;
    minute_t start_minute_reg;
    mask_t   day_mask_reg;
    minute_t run_minutes_reg;

    logic    in_valid_reg;
    logic [1:0] kind_reg;
    day_t    weekday_reg;
    hour_t   hour_reg;
    minute_t minute_reg;
    logic    switch_reg;
    logic    mode_reg;

    logic    relay_reg, relay_next;
    logic    auto_reg, auto_next;
    logic    pending_reg, pending_next;
    logic    active_reg, active_next;
    logic    empty_reg, empty_next;
    day_t    start_day_reg, start_day_next;
    day_t    stop_day_reg, stop_day_next;
    hour_t   stop_hour_reg, stop_hour_next;
    minute_t stop_minute_reg, stop_minute_next;

    logic    out_valid_reg;
    logic    advance;
    logic    process;
    day_t    wd;
    hour_t   sh;
    minute_t sm;
    minute_t rm;
    logic    at_start;
    logic    at_stop;
    sched_t  sched;

    assign advance  = !out_valid_reg || !out_stall;
    assign process  = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    assign wd = (weekday_reg == 3'd0) ? SUNDAY : weekday_reg;
    assign sh = (start_hour_reg > LAST_HOUR) ? LAST_HOUR : start_hour_reg;
    assign sm = (start_minute_reg > LAST_MINUTE) ? LAST_MINUTE : start_minute_reg;
    assign rm = (run_minutes_reg > MAX_RUN) ? MAX_RUN : run_minutes_reg;

    wrts_sched u_sched (
        .weekday      (wd),
        .hour         (hour_reg),
        .minute       (minute_reg),
        .start_hour   (sh),
        .start_minute (sm),
        .run_minutes  (rm),
        .day_mask     (day_mask_reg),
        .sched        (sched)
    );

    always_comb
    begin
        relay_next       = relay_reg;
        auto_next        = auto_reg;
        pending_next     = pending_reg;
        active_next      = active_reg;
        empty_next       = empty_reg;
        start_day_next   = start_day_reg;
        stop_day_next    = stop_day_reg;
        stop_hour_next   = stop_hour_reg;
        stop_minute_next = stop_minute_reg;
        at_start         = 1'b0;
        at_stop          = 1'b0;
        case (kind_reg)
            KIND_TICK:
            begin
                if (auto_reg)
                begin
                    if (pending_reg)
                    begin
                        active_next  = 1'b0;
                        pending_next = 1'b0;
                        empty_next   = !sched.found;
                        if (sched.found)
                        begin
                            start_day_next   = sched.start_day;
                            stop_day_next    = sched.stop_day;
                            stop_hour_next   = sched.stop_hour;
                            stop_minute_next = sched.stop_minute;
                        end
                    end
                    at_start = (wd == start_day_next) && (hour_reg == sh) && (minute_reg == sm);
                    at_stop  = (wd == stop_day_next) && (hour_reg == stop_hour_next)
                               && (minute_reg == stop_minute_next);
                    if (!empty_next)
                    begin
                        if (at_start && !active_next)
                        begin
                            relay_next  = 1'b1;
                            active_next = 1'b1;
                        end
                        else if (at_stop && active_next)
                        begin
                            relay_next   = 1'b0;
                            active_next  = 1'b0;
                            pending_next = 1'b1;
                        end
                    end
                end
            end
            KIND_SWITCH:
            begin
                auto_next    = 1'b0;
                pending_next = 1'b1;
                relay_next   = switch_reg;
            end
            KIND_MODE:
            begin
                auto_next = mode_reg;
                if (mode_reg)
                begin
                    pending_next = 1'b1;
                end
            end
            default:
            begin
                relay_next = relay_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_hour_reg   <= 5'd10;
            start_minute_reg <= 6'd0;
            day_mask_reg     <= 7'd127;
            run_minutes_reg  <= 6'd1;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            relay_reg        <= 1'b0;
            auto_reg         <= 1'b1;
            pending_reg      <= 1'b1;
            active_reg       <= 1'b0;
            empty_reg        <= 1'b0;
            start_day_reg    <= SUNDAY;
            stop_day_reg     <= SUNDAY;
            stop_hour_reg    <= 5'd10;
            stop_minute_reg  <= 6'd1;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (process)
            begin
                relay_reg       <= relay_next;
                auto_reg        <= auto_next;
                active_reg      <= active_next;
                empty_reg       <= empty_next;
                start_day_reg   <= start_day_next;
                stop_day_reg    <= stop_day_next;
                stop_hour_reg   <= stop_hour_next;
                stop_minute_reg <= stop_minute_next;
            end
            if (cfg_we)
            begin
                pending_reg <= 1'b1;
            end
            else if (process)
            begin
                pending_reg <= pending_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_START_HOUR:   start_hour_reg   <= cfg_wdata[4:0];
                    CFG_START_MINUTE: start_minute_reg <= cfg_wdata[5:0];
                    CFG_DAY_MASK:     day_mask_reg     <= cfg_wdata;
                    CFG_RUN_MINUTES:  run_minutes_reg  <= cfg_wdata[5:0];
                    default:          run_minutes_reg  <= run_minutes_reg;
                endcase
            end
        end
    end

    // capture the item and the result payload
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            kind_reg    <= kind;
            weekday_reg <= weekday;
            hour_reg    <= hour;
            minute_reg  <= minute;
            switch_reg  <= switch_value;
            mode_reg    <= mode_value;
        end
        if (process)
        begin
            relay_drive      <= relay_next;
            auto_mode        <= auto_next;
            schedule_empty   <= empty_next;
            next_start_day   <= start_day_next;
            next_stop_day    <= stop_day_next;
            next_stop_hour   <= stop_hour_next;
            next_stop_minute <= stop_minute_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire
